### rtl/core/pppc_pkg.sv
// Shared types, codes and the CORDIC arctangent table for the pose proximity check.
package pppc_pkg;

  localparam int PosW     = 32;
  localparam int DiffW    = 33;
  localparam int SqW      = 66;
  localparam int RootW    = 34;
  localparam int RemW     = 38;
  localparam int CordW    = 36;
  localparam int AngW     = 32;
  localparam int DistW    = 33;
  localparam int YawW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 33;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_INVALID = 2'd0;
  localparam status_t STATUS_WITHIN  = 2'd1;
  localparam status_t STATUS_OUTSIDE = 2'd2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POS_TOL     = 2'd0;
  localparam cfg_idx_t CFG_REQUIRE_YAW = 2'd1;
  localparam cfg_idx_t CFG_YAW_TOL     = 2'd2;

  typedef logic [AngW-1:0] ang_t;

  // atan(2^-i) in units of 2^32 per turn
  localparam ang_t ATAN_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  localparam ang_t ANG_QUARTER  = 32'h4000_0000;
  localparam ang_t ANG_NQUARTER = 32'hC000_0000;

endpackage

### rtl/core/planar_pose_proximity_check.sv
// Pose proximity check: distance, yaw error and tolerance verdict for a pose pair.
//
// Usage: present a target and an actual pose (x, y in Q15.16, yaw quaternion
// z, w in Q1.14) on the in_ channel; one result per request comes out on the
// out_ channel in the same order. A request is taken when in_valid is high
// and in_stall is low; a result is taken when out_valid is high and out_stall
// is low. Tolerances are written over the cfg_ channel (always ready) while
// no request is in flight.
// Throughput is one request per cycle while out_stall is low: every
// stage is registered, the square root resolves one result bit per stage
// (34 stages) and the CORDIC runs one iteration per stage alongside it.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling any empty slots; in_stall rises only once
// every stage holds a request.
// Reset (rst_n low, synchronous) empties the pipeline and sets the position
// and yaw tolerances to 0 with yaw required.
module planar_pose_proximity_check
  import pppc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PosW-1:0]  in_target_x,
  input  logic signed [PosW-1:0]  in_target_y,
  input  logic signed [15:0]      in_target_qz,
  input  logic signed [15:0]      in_target_qw,
  input  logic signed [PosW-1:0]  in_actual_x,
  input  logic signed [PosW-1:0]  in_actual_y,
  input  logic signed [15:0]      in_actual_qz,
  input  logic signed [15:0]      in_actual_qw,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [DistW-1:0]        out_distance,
  output logic [YawW-1:0]         out_yaw_error,
  output logic                    out_tol_met,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgDataW-1:0]     cfg_data
);

  localparam int NStg    = 40;
  localparam int SqrtS0  = 4;
  localparam int SqrtN   = RootW;
  localparam int RndStg  = SqrtS0 + SqrtN;   // 38
  localparam int OutStg  = RndStg + 1;       // 39
  localparam int CordN   = CORDIC_STAGES;

  // configuration
  logic [DistW-1:0] pos_tol_r;
  logic             req_yaw_r;
  logic [YawW-1:0]  yaw_tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tol_r <= '0;
      req_yaw_r <= 1'b1;
      yaw_tol_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POS_TOL:     pos_tol_r <= cfg_data;
        CFG_REQUIRE_YAW: req_yaw_r <= cfg_data[0];
        CFG_YAW_TOL:     yaw_tol_r <= cfg_data[YawW-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it or any stage ahead has room
  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || !out_stall;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // invalid flag travels with the request
  logic inv_r [OutStg];

  always_ff @(posedge clk) begin
    if (en[0]) inv_r[0] <= (in_target_qz == 16'sd0 && in_target_qw == 16'sd0) ||
                           (in_actual_qz == 16'sd0 && in_actual_qw == 16'sd0);
    for (int i = 1; i < OutStg; i++) begin
      if (en[i]) inv_r[i] <= inv_r[i-1];
    end
  end

  // ---------------- distance path ----------------
  logic signed [DiffW-1:0] dx_r, dy_r;
  logic [DiffW-1:0]        adx_r, ady_r;
  logic [SqW-1:0]          sqx_r, sqy_r;
  logic [SqW+1:0]          rad_r  [SqrtN+1];
  logic [RemW-1:0]         rem_r  [SqrtN+1];
  logic [RootW-1:0]        root_r [SqrtN+1];
  logic [DistW-1:0]        dist_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= {in_actual_x[PosW-1], in_actual_x} - {in_target_x[PosW-1], in_target_x};
      dy_r <= {in_actual_y[PosW-1], in_actual_y} - {in_target_y[PosW-1], in_target_y};
    end
    if (en[1]) begin
      adx_r <= dx_r[DiffW-1] ? DiffW'(-dx_r) : DiffW'(dx_r);
      ady_r <= dy_r[DiffW-1] ? DiffW'(-dy_r) : DiffW'(dy_r);
    end
    if (en[2]) begin
      sqx_r <= {{(SqW-DiffW){1'b0}}, adx_r} * {{(SqW-DiffW){1'b0}}, adx_r};
      sqy_r <= {{(SqW-DiffW){1'b0}}, ady_r} * {{(SqW-DiffW){1'b0}}, ady_r};
    end
    if (en[3]) begin
      rad_r[0]  <= {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
    logic [RemW-1:0] rem_sh, trial;
    assign rem_sh = {rem_r[k][RemW-3:0], rad_r[k][SqW+1:SqW]};
    assign trial  = {{(RemW-RootW-2){1'b0}}, root_r[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en[SqrtS0+k]) begin
        rad_r[k+1] <= {rad_r[k][SqW-1:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r[k+1]  <= rem_sh - trial;
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rem_sh;
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- yaw path ----------------
  logic signed [CordW-1:0] tx_r [CordN+1], ty_r [CordN+1];
  logic signed [CordW-1:0] ax_r [CordN+1], ay_r [CordN+1];
  ang_t                    tang_r [RndStg], aang_r [RndStg];

  function automatic void pre_rot(input logic signed [15:0] qz,
                                  input logic signed [15:0] qw,
                                  output logic signed [CordW-1:0] xo,
                                  output logic signed [CordW-1:0] yo,
                                  output ang_t ao);
    logic signed [CordW-1:0] x0, y0;
    x0 = {{(CordW-32){qw[15]}}, qw, 16'd0};
    y0 = {{(CordW-32){qz[15]}}, qz, 16'd0};
    if (!x0[CordW-1]) begin
      xo = x0; yo = y0; ao = '0;
    end else if (!y0[CordW-1]) begin
      xo = y0; yo = -x0; ao = ANG_QUARTER;
    end else begin
      xo = -y0; yo = x0; ao = ANG_NQUARTER;
    end
  endfunction

  always_ff @(posedge clk) begin
    logic signed [CordW-1:0] xa, ya, xb, yb;
    ang_t aa, ab;
    pre_rot(in_target_qz, in_target_qw, xa, ya, aa);
    pre_rot(in_actual_qz, in_actual_qw, xb, yb, ab);
    if (en[0]) begin
      tx_r[0] <= xa; ty_r[0] <= ya; tang_r[0] <= aa;
      ax_r[0] <= xb; ay_r[0] <= yb; aang_r[0] <= ab;
    end
  end

  for (genvar s = 1; s < RndStg; s++) begin : g_cord
    if (s <= CordN) begin : g_iter
      localparam int Sh = s - 1;
      logic signed [CordW-1:0] txs, tys, axs, ays;
      assign txs = tx_r[s-1] >>> Sh;
      assign tys = ty_r[s-1] >>> Sh;
      assign axs = ax_r[s-1] >>> Sh;
      assign ays = ay_r[s-1] >>> Sh;
      always_ff @(posedge clk) begin
        if (en[s]) begin
          if (!ty_r[s-1][CordW-1]) begin
            tx_r[s] <= tx_r[s-1] + tys; ty_r[s] <= ty_r[s-1] - txs;
            tang_r[s] <= tang_r[s-1] + ATAN_TABLE[Sh];
          end else begin
            tx_r[s] <= tx_r[s-1] - tys; ty_r[s] <= ty_r[s-1] + txs;
            tang_r[s] <= tang_r[s-1] - ATAN_TABLE[Sh];
          end
          if (!ay_r[s-1][CordW-1]) begin
            ax_r[s] <= ax_r[s-1] + ays; ay_r[s] <= ay_r[s-1] - axs;
            aang_r[s] <= aang_r[s-1] + ATAN_TABLE[Sh];
          end else begin
            ax_r[s] <= ax_r[s-1] - ays; ay_r[s] <= ay_r[s-1] + axs;
            aang_r[s] <= aang_r[s-1] - ATAN_TABLE[Sh];
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en[s]) begin
          tang_r[s] <= tang_r[s-1];
          aang_r[s] <= aang_r[s-1];
        end
      end
    end
  end

  // ---------------- round distance, wrap yaw ----------------
  ang_t            diff;
  logic [AngW:0]   absd, absd_rnd;
  logic [YawW-1:0] err_r;
  logic [RemW-1:0] root_ext;

  assign diff     = {aang_r[RndStg-1][AngW-2:0], 1'b0} - {tang_r[RndStg-1][AngW-2:0], 1'b0};
  assign absd     = diff[AngW-1] ? ({1'b1, {AngW{1'b0}}} - {1'b0, diff}) : {1'b0, diff};
  assign absd_rnd = absd + (AngW+1)'(32'h8000);
  assign root_ext = {{(RemW-RootW){1'b0}}, root_r[SqrtN]};

  always_ff @(posedge clk) begin
    if (en[RndStg]) begin
      if (rem_r[SqrtN] > root_ext) dist_r <= DistW'(root_r[SqrtN] + 1'b1);
      else                         dist_r <= DistW'(root_r[SqrtN]);
      err_r <= absd_rnd[YawW+15:16];
    end
  end

  // ---------------- verdict and output register ----------------
  logic ok;
  assign ok = (dist_r <= pos_tol_r) && (!req_yaw_r || err_r <= yaw_tol_r);

  always_ff @(posedge clk) begin
    if (en[OutStg]) begin
      if (inv_r[OutStg-1]) begin
        out_status    <= STATUS_INVALID;
        out_distance  <= '0;
        out_yaw_error <= '0;
        out_tol_met   <= 1'b0;
      end else begin
        out_status    <= ok ? STATUS_WITHIN : STATUS_OUTSIDE;
        out_distance  <= dist_r;
        out_yaw_error <= err_r;
        out_tol_met   <= ok;
      end
    end
  end

  assign out_valid = v_r[OutStg];

endmodule
